@@ hw/rtl/ttsched_pkg.sv @@
// Shared constants, codes and types of the tick task scheduler table.
package ttsched_pkg;

  // Table size and tick length
  localparam int SLOTS       = 8;
  localparam int TICK_MS     = 10;
  localparam int MAX_RESULTS = 8;
  localparam int SLOT_IW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  // Field widths
  localparam int CMD_W     = 2;
  localparam int HANDLE_W  = 16;
  localparam int MS_W      = 32;
  localparam int DEL_W     = 3;
  localparam int KIND_W    = 3;
  localparam int SLOT_OW   = 4;
  localparam int DELAY_W   = 29;
  localparam int PEND_W    = 8;

  localparam logic [DELAY_W-1:0] DELAY_MAX = {DELAY_W{1'b1}};
  localparam logic [PEND_W-1:0]  PEND_MAX  = {PEND_W{1'b1}};

  // Reciprocal of the tick length for the ms to tick conversion
  localparam int          TICK_SH  = $clog2(TICK_MS);
  localparam int          RECIP_SH = 31 + TICK_SH;
  localparam logic [31:0] RECIP    = 32'((64'd1 << RECIP_SH) / TICK_MS);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DEL  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DISP = 2'd3;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_TICK = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ADD  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DEL  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RUN  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NONE = 3'd4;

  // Request queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_IW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef logic [DELAY_W-1:0] delay_t;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [HANDLE_W-1:0] handle;
    delay_t              delay_tk;
    delay_t              period_tk;
    logic [DEL_W-1:0]    del_slot;
  } sched_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

@@ hw/rtl/ttsched_if.sv @@
// Request and result channel interfaces of the tick task scheduler table.
interface ttsched_in_if;
  logic                               valid;
  logic                               ready;
  logic [ttsched_pkg::CMD_W-1:0]      cmd;
  logic [ttsched_pkg::HANDLE_W-1:0]   task_handle;
  logic [ttsched_pkg::MS_W-1:0]       delay_ms;
  logic [ttsched_pkg::MS_W-1:0]       period_ms;
  logic [ttsched_pkg::DEL_W-1:0]      slot_to_delete;

  modport source (output valid, cmd, task_handle, delay_ms, period_ms, slot_to_delete,
                  input ready);
  modport sink   (input valid, cmd, task_handle, delay_ms, period_ms, slot_to_delete,
                  output ready);
endinterface

interface ttsched_out_if;
  logic                               valid;
  logic                               ready;
  logic [ttsched_pkg::KIND_W-1:0]     kind;
  logic [ttsched_pkg::SLOT_OW-1:0]    slot;
  logic [ttsched_pkg::HANDLE_W-1:0]   run_handle;
  logic                               last;

  modport source (output valid, kind, slot, run_handle, last, input ready);
  modport sink   (input valid, kind, slot, run_handle, last, output ready);
endinterface

@@ hw/rtl/ttsched_fifo.sv @@
// Short request queue between the front and the back of the scheduler.
module ttsched_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  ttsched_pkg::sched_req_t push_data,
  input  logic                    pop,
  output ttsched_pkg::sched_req_t pop_data,
  output ttsched_pkg::fifo_stat_t stat
);
  import ttsched_pkg::*;

  sched_req_t           mem_r [FIFO_DEPTH];
  logic [FIFO_IW-1:0]   wr_r;
  logic [FIFO_IW-1:0]   rd_r;
  logic [FIFO_CW-1:0]   cnt_r;

  assign stat.full  = (cnt_r == FIFO_CW'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_data   = mem_r[rd_r];

  // Store a pushed request
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == FIFO_IW'(FIFO_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == FIFO_IW'(FIFO_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  ap_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!stat.full || pop))
    else $error("request pushed into full queue");

  ap_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("request popped from empty queue");

endmodule

@@ hw/rtl/ttsched_front.sv @@
// Front end: accepts requests and converts add times from ms to ticks.
module ttsched_front (
  input  logic                    clk,
  input  logic                    rst_n,
  ttsched_in_if.sink              in_ch,
  output logic                    push,
  output ttsched_pkg::sched_req_t push_data,
  input  ttsched_pkg::fifo_stat_t fst
);
  import ttsched_pkg::*;

  localparam logic [1:0] FR_IDLE = 2'd0;
  localparam logic [1:0] FR_MUL  = 2'd1;
  localparam logic [1:0] FR_COR  = 2'd2;

  logic [1:0]          st_r, st_nxt;
  logic [CMD_W-1:0]    cmd_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [DEL_W-1:0]    del_r;
  logic [MS_W-1:0]     dms_r;
  logic [MS_W-1:0]     pms_r;
  logic [63:0]         dprod_r;
  logic [63:0]         pprod_r;

  // Finish the reciprocal estimate: one correction step, then saturate
  function automatic delay_t ms_fix(input logic [MS_W-1:0] ms, input logic [63:0] prod);
    logic [31:0] q0;
    logic [31:0] qd;
    logic [31:0] rem;
    logic [32:0] q;
    q0  = 32'(prod >> RECIP_SH);
    qd  = q0 * 32'(TICK_MS);
    rem = ms - qd;
    q   = {1'b0, q0} + ((rem >= 32'(TICK_MS)) ? 33'd1 : 33'd0);
    if (q > 33'(DELAY_MAX)) begin
      return DELAY_MAX;
    end
    return DELAY_W'(q);
  endfunction

  assign in_ch.ready = (st_r == FR_IDLE);

  assign push               = (st_r == FR_COR) && !fst.full;
  assign push_data.cmd       = cmd_r;
  assign push_data.handle    = handle_r;
  assign push_data.delay_tk  = ms_fix(dms_r, dprod_r);
  assign push_data.period_tk = ms_fix(pms_r, pprod_r);
  assign push_data.del_slot  = del_r;

  // Sequence one request through multiply and correction
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      FR_IDLE: if (in_ch.valid) st_nxt = FR_MUL;
      FR_MUL:  st_nxt = FR_COR;
      FR_COR:  if (!fst.full) st_nxt = FR_IDLE;
      default: st_nxt = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= FR_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Capture the request and form the reciprocal products
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cmd_r    <= in_ch.cmd;
      handle_r <= in_ch.task_handle;
      del_r    <= in_ch.slot_to_delete;
      dms_r    <= in_ch.delay_ms;
      pms_r    <= in_ch.period_ms;
    end
    if (st_r == FR_MUL) begin
      dprod_r <= {32'd0, dms_r} * {32'd0, RECIP};
      pprod_r <= {32'd0, pms_r} * {32'd0, RECIP};
    end
  end

endmodule

@@ hw/rtl/ttsched_back.sv @@
// Back end: slot table, command execution and result register.
module ttsched_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ttsched_pkg::fifo_stat_t fst,
  input  ttsched_pkg::sched_req_t pop_data,
  output logic                    pop,
  ttsched_out_if.source           out_ch
);
  import ttsched_pkg::*;

  localparam logic BK_IDLE = 1'b0;
  localparam logic BK_EXEC = 1'b1;

  logic                 st_r, st_nxt;
  sched_req_t           cur_r, cur_nxt;
  logic [SLOT_IW-1:0]   scan_r, scan_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  logic                 valid_r  [SLOTS];
  logic [HANDLE_W-1:0]  handle_r [SLOTS];
  delay_t               delay_r  [SLOTS];
  delay_t               period_r [SLOTS];
  logic [PEND_W-1:0]    pend_r   [SLOTS];
  logic                 valid_nxt  [SLOTS];
  logic [HANDLE_W-1:0]  handle_nxt [SLOTS];
  delay_t               delay_nxt  [SLOTS];
  delay_t               period_nxt [SLOTS];
  logic [PEND_W-1:0]    pend_nxt   [SLOTS];

  logic                 out_valid_r;
  logic [KIND_W-1:0]    out_kind_r, out_kind_nxt;
  logic [SLOT_OW-1:0]   out_slot_r, out_slot_nxt;
  logic [HANDLE_W-1:0]  out_handle_r, out_handle_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 emit;
  logic                 out_free;

  logic [SLOTS-1:0]     pend_nz;
  logic [SLOTS-1:0]     cand;
  logic [SLOTS-1:0]     free_vec;
  logic [SLOT_IW-1:0]   found;
  logic [SLOT_IW-1:0]   free_idx;
  logic                 has_free;
  logic                 more;
  logic                 disp_last;
  logic [SLOT_IW-1:0]   del_idx;

  assign out_free = !out_valid_r || out_ch.ready;
  assign del_idx  = SLOT_IW'(cur_r.del_slot);

  // Classify slots: pending runs at or after the scan point, free slots
  always_comb begin
    found    = '0;
    free_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      pend_nz[i]  = (pend_r[i] != '0);
      cand[i]     = pend_nz[i] && (i >= int'(scan_r));
      free_vec[i] = !valid_r[i];
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (cand[i]) found = SLOT_IW'(i);
      if (free_vec[i]) free_idx = SLOT_IW'(i);
    end
    has_free  = |free_vec;
    more      = |(cand & (cand - 1'b1));
    disp_last = !more || (cnt_r == CNT_W'(MAX_RESULTS - 1));
  end

  // Execute the current request
  always_comb begin
    st_nxt         = st_r;
    cur_nxt        = cur_r;
    scan_nxt       = scan_r;
    cnt_nxt        = cnt_r;
    pop            = 1'b0;
    emit           = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_slot_nxt   = out_slot_r;
    out_handle_nxt = out_handle_r;
    out_last_nxt   = out_last_r;
    for (int i = 0; i < SLOTS; i++) begin
      valid_nxt[i]  = valid_r[i];
      handle_nxt[i] = handle_r[i];
      delay_nxt[i]  = delay_r[i];
      period_nxt[i] = period_r[i];
      pend_nxt[i]   = pend_r[i];
    end

    unique case (st_r)
      BK_IDLE: begin
        if (!fst.empty) begin
          pop      = 1'b1;
          cur_nxt  = pop_data;
          scan_nxt = '0;
          cnt_nxt  = '0;
          st_nxt   = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (out_free) begin
          emit           = 1'b1;
          out_slot_nxt   = '0;
          out_handle_nxt = '0;
          out_last_nxt   = 1'b1;
          st_nxt         = BK_IDLE;
          unique case (cur_r.cmd)
            CMD_TICK: begin
              out_kind_nxt = KIND_TICK;
              for (int i = 0; i < SLOTS; i++) begin
                if (valid_r[i]) begin
                  if (delay_r[i] == '0) begin
                    if (pend_r[i] != PEND_MAX) pend_nxt[i] = pend_r[i] + 1'b1;
                    if (period_r[i] != '0) delay_nxt[i] = period_r[i];
                  end else begin
                    delay_nxt[i] = delay_r[i] - 1'b1;
                  end
                end
              end
            end
            CMD_ADD: begin
              out_kind_nxt = KIND_ADD;
              if (has_free) begin
                out_slot_nxt         = SLOT_OW'(free_idx);
                valid_nxt[free_idx]  = 1'b1;
                handle_nxt[free_idx] = cur_r.handle;
                delay_nxt[free_idx]  = cur_r.delay_tk;
                period_nxt[free_idx] = cur_r.period_tk;
                pend_nxt[free_idx]   = '0;
              end else begin
                out_slot_nxt = SLOT_OW'(SLOTS);
              end
            end
            CMD_DEL: begin
              out_kind_nxt = KIND_DEL;
              out_slot_nxt = SLOT_OW'(cur_r.del_slot);
              if (int'(cur_r.del_slot) < SLOTS) begin
                valid_nxt[del_idx]  = 1'b0;
                handle_nxt[del_idx] = '0;
                delay_nxt[del_idx]  = '0;
                period_nxt[del_idx] = '0;
                pend_nxt[del_idx]   = '0;
              end
            end
            CMD_DISP: begin
              if (|cand) begin
                // Report one ready slot, lower its count, drop one-shot tasks
                out_kind_nxt   = KIND_RUN;
                out_slot_nxt   = SLOT_OW'(found);
                out_handle_nxt = handle_r[found];
                out_last_nxt   = disp_last;
                pend_nxt[found] = pend_r[found] - 1'b1;
                if (period_r[found] == '0) begin
                  valid_nxt[found]  = 1'b0;
                  handle_nxt[found] = '0;
                  delay_nxt[found]  = '0;
                  period_nxt[found] = '0;
                  pend_nxt[found]   = '0;
                end
                scan_nxt = SLOT_IW'(int'(found) + 1);
                cnt_nxt  = cnt_r + 1'b1;
                st_nxt   = disp_last ? BK_IDLE : BK_EXEC;
              end else begin
                out_kind_nxt = KIND_NONE;
              end
            end
            default: out_kind_nxt = KIND_TICK;
          endcase
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  // Hold control state and slot table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        valid_r[i]  <= 1'b0;
        handle_r[i] <= '0;
        delay_r[i]  <= '0;
        period_r[i] <= '0;
        pend_r[i]   <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      for (int i = 0; i < SLOTS; i++) begin
        valid_r[i]  <= valid_nxt[i];
        handle_r[i] <= handle_nxt[i];
        delay_r[i]  <= delay_nxt[i];
        period_r[i] <= period_nxt[i];
        pend_r[i]   <= pend_nxt[i];
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    scan_r       <= scan_nxt;
    cnt_r        <= cnt_nxt;
    out_kind_r   <= out_kind_nxt;
    out_slot_r   <= out_slot_nxt;
    out_handle_r <= out_handle_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_kind_r;
  assign out_ch.slot       = out_slot_r;
  assign out_ch.run_handle = out_handle_r;
  assign out_ch.last       = out_last_r;

  ap_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_NONE) |-> out_last_r)
    else $error("nothing-ready result without last flag");

  ap_free_not_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_nz & free_vec) == '0)
    else $error("free slot holds pending runs");

  ap_disp_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && out_kind_nxt == KIND_RUN && !out_last_nxt) |=> (st_r == BK_EXEC && |cand))
    else $error("dispatch stopped before its last result");

endmodule

@@ hw/rtl/tick_task_scheduler_table_unit.sv @@
// Top level of the tick task scheduler table: front end, request queue and back end.
//
// Usage: requests enter on in_ch (valid/ready); a request is taken at a clock edge
// where valid and ready are both high. cmd selects tick, add, delete or dispatch.
// Results leave on out_ch (valid/ready), one per request except dispatch, which
// gives one result per ready slot in slot order (at most eight) or a single
// nothing-ready result; last marks the final result of each request.
// Path: a request is captured at the accepting edge, then passes a reciprocal
// multiply state and a correction state in the front end, is loaded from the
// queue by the back end, and its first result is then registered.
// Flow: the front end takes a new request only after it has pushed the last one
// into the queue; the back end loads a request and emits all its results before
// it pops the next. A two-entry queue lets the front end keep accepting while the
// back end is busy.
// Reset (synchronous, rst_n low) frees every slot and clears all pending runs.
// When the receiver holds ready low, the result register holds, the back end and
// then the queue fill, and in_ch.ready falls until results drain.
module tick_task_scheduler_table_unit (
  input logic         clk,
  input logic         rst_n,
  ttsched_in_if.sink  in_ch,
  ttsched_out_if.source out_ch
);
  import ttsched_pkg::*;

  logic       push;
  logic       pop;
  sched_req_t push_data;
  sched_req_t pop_data;
  fifo_stat_t fst;

  ttsched_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .push      (push),
    .push_data (push_data),
    .fst       (fst)
  );

  ttsched_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (fst)
  );

  ttsched_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .fst      (fst),
    .pop_data (pop_data),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the tick task scheduler table, with its own table predictor.
`timescale 1ns / 1ps

module tb;
  import ttsched_pkg::*;

  localparam int  DIR_N        = 25;
  localparam int  RAND_PER_PH  = 40;
  localparam int  SAT_TICKS    = 260;
  localparam int  DRAIN_CYCLES = 50;
  localparam int  MAX_PRINTED  = 100;
  localparam longint TIMEOUT_NS = 64'd8_000_000;

  // One request and one result as seen on the channels
  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [HANDLE_W-1:0] handle;
    logic [MS_W-1:0]     delay_ms;
    logic [MS_W-1:0]     period_ms;
    logic [DEL_W-1:0]    del_slot;
  } sched_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SLOT_OW-1:0]  slot;
    logic [HANDLE_W-1:0] handle;
    logic                last;
  } sched_res_t;

  typedef struct packed {
    sched_cmd_t c;
    logic       typed;
    sched_res_t want;
  } dir_row_t;

  localparam sched_res_t NO_RES = '0;

  logic clk;
  logic rst_n;

  ttsched_in_if  req_ch ();
  ttsched_out_if res_ch ();

  tick_task_scheduler_table_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (res_ch)
  );

  // Predicted task table
  logic                tbl_valid   [SLOTS];
  logic [HANDLE_W-1:0] tbl_handle  [SLOTS];
  delay_t              tbl_delay   [SLOTS];
  delay_t              tbl_period  [SLOTS];
  logic [PEND_W-1:0]   tbl_pending [SLOTS];

  sched_res_t pred_buf [MAX_RESULTS];
  int         pred_n;
  sched_res_t due_results [$];

  int err_cnt       = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Directed requests; typed expectations only where they are obvious
  dir_row_t dir_tab [DIR_N] = '{
    '{'{CMD_DISP, 16'h0000, 32'd0, 32'd0, 3'd0}, 1'b1, '{KIND_NONE, 4'd0, 16'h0, 1'b1}},
    '{'{CMD_TICK, 16'h0000, 32'd0, 32'd0, 3'd0}, 1'b1, '{KIND_TICK, 4'd0, 16'h0, 1'b1}},
    '{'{CMD_DEL,  16'h0000, 32'd0, 32'd0, 3'd5}, 1'b1, '{KIND_DEL,  4'd5, 16'h0, 1'b1}},
    '{'{CMD_ADD,  16'hFFFF, 32'd0, 32'd0, 3'd0}, 1'b1, '{KIND_ADD,  4'd0, 16'h0, 1'b1}},
    '{'{CMD_ADD,  16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7}, 1'b1,
      '{KIND_ADD, 4'd1, 16'h0, 1'b1}},
    '{'{CMD_ADD,  16'h1234, 32'd9,   32'd10,  3'd0}, 1'b1, '{KIND_ADD, 4'd2, 16'h0, 1'b1}},
    '{'{CMD_ADD,  16'h5A5A, 32'd25,  32'd19,  3'd0}, 1'b1, '{KIND_ADD, 4'd3, 16'h0, 1'b1}},
    '{'{CMD_ADD,  16'hA5A5, 32'd10,  32'd0,   3'd0}, 1'b1, '{KIND_ADD, 4'd4, 16'h0, 1'b1}},
    '{'{CMD_ADD,  16'h8001, 32'd40,  32'd30,  3'd0}, 1'b1, '{KIND_ADD, 4'd5, 16'h0, 1'b1}},
    '{'{CMD_ADD,  16'h7FFE, 32'd0,   32'd20,  3'd0}, 1'b1, '{KIND_ADD, 4'd6, 16'h0, 1'b1}},
    '{'{CMD_ADD,  16'h00FF, 32'd5,   32'd9,   3'd0}, 1'b1, '{KIND_ADD, 4'd7, 16'h0, 1'b1}},
    '{'{CMD_ADD,  16'hBEEF, 32'd100, 32'd100, 3'd0}, 1'b1,
      '{KIND_ADD, 4'(SLOTS), 16'h0, 1'b1}},
    '{'{CMD_TICK, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7}, 1'b1,
      '{KIND_TICK, 4'd0, 16'h0, 1'b1}},
    '{'{CMD_TICK, 16'h0000, 32'd0, 32'd0, 3'd0}, 1'b1, '{KIND_TICK, 4'd0, 16'h0, 1'b1}},
    '{'{CMD_DISP, 16'h0000, 32'd0, 32'd0, 3'd0}, 1'b0, NO_RES},
    '{'{CMD_DISP, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7}, 1'b0, NO_RES},
    '{'{CMD_DEL,  16'h0000, 32'd0, 32'd0, 3'd1}, 1'b1, '{KIND_DEL, 4'd1, 16'h0, 1'b1}},
    '{'{CMD_DEL,  16'h0000, 32'd0, 32'd0, 3'd7}, 1'b1, '{KIND_DEL, 4'd7, 16'h0, 1'b1}},
    '{'{CMD_DEL,  16'hFFFF, 32'd0, 32'd0, 3'd7}, 1'b1, '{KIND_DEL, 4'd7, 16'h0, 1'b1}},
    '{'{CMD_TICK, 16'h0000, 32'd0, 32'd0, 3'd0}, 1'b1, '{KIND_TICK, 4'd0, 16'h0, 1'b1}},
    '{'{CMD_ADD,  16'h0F0F, 32'hAAAA_AAAA, 32'h5555_5555, 3'd2}, 1'b0, NO_RES},
    '{'{CMD_TICK, 16'h0000, 32'd0, 32'd0, 3'd0}, 1'b1, '{KIND_TICK, 4'd0, 16'h0, 1'b1}},
    '{'{CMD_DISP, 16'h0000, 32'd0, 32'd0, 3'd0}, 1'b0, NO_RES},
    '{'{CMD_DEL,  16'h0000, 32'd0, 32'd0, 3'd0}, 1'b1, '{KIND_DEL, 4'd0, 16'h0, 1'b1}},
    '{'{CMD_DISP, 16'h0000, 32'd0, 32'd0, 3'd0}, 1'b0, NO_RES}
  };

  // Convert milliseconds to ticks, saturating at the counter width
  function automatic delay_t ms_to_tick(input logic [MS_W-1:0] ms);
    logic [MS_W-1:0] t;
    t = ms / 32'(TICK_MS);
    if (t > MS_W'(DELAY_MAX)) t = MS_W'(DELAY_MAX);
    return t[DELAY_W-1:0];
  endfunction

  function automatic void clear_slot(input int i);
    tbl_valid[i]   = 1'b0;
    tbl_handle[i]  = '0;
    tbl_delay[i]   = '0;
    tbl_period[i]  = '0;
    tbl_pending[i] = '0;
  endfunction

  function automatic void push_pred(input logic [KIND_W-1:0] k,
                                    input logic [SLOT_OW-1:0] s,
                                    input logic [HANDLE_W-1:0] h);
    pred_buf[pred_n] = '{k, s, h, 1'b0};
    pred_n++;
  endfunction

  // Advance the predicted table by one request and fill pred_buf with its results
  function automatic void predict_sched(input sched_cmd_t c);
    int idx;
    pred_n = 0;
    case (c.cmd)
      CMD_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_valid[i]) begin
            if (tbl_delay[i] == '0) begin
              if (tbl_pending[i] != PEND_MAX) tbl_pending[i]++;
              if (tbl_period[i] != '0) tbl_delay[i] = tbl_period[i];
            end else begin
              tbl_delay[i]--;
            end
          end
        end
        push_pred(KIND_TICK, '0, '0);
      end
      CMD_ADD: begin
        idx = SLOTS;
        for (int i = SLOTS - 1; i >= 0; i--)
          if (!tbl_valid[i]) idx = i;
        if (idx < SLOTS) begin
          tbl_valid[idx]   = 1'b1;
          tbl_handle[idx]  = c.handle;
          tbl_delay[idx]   = ms_to_tick(c.delay_ms);
          tbl_period[idx]  = ms_to_tick(c.period_ms);
          tbl_pending[idx] = '0;
        end
        push_pred(KIND_ADD, SLOT_OW'(idx), '0);
      end
      CMD_DEL: begin
        if (int'(c.del_slot) < SLOTS) clear_slot(int'(c.del_slot));
        push_pred(KIND_DEL, SLOT_OW'(c.del_slot), '0);
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_pending[i] != '0 && pred_n < MAX_RESULTS) begin
            push_pred(KIND_RUN, SLOT_OW'(i), tbl_handle[i]);
            tbl_pending[i]--;
            if (tbl_period[i] == '0) clear_slot(i);
          end
        end
        if (pred_n == 0) push_pred(KIND_NONE, '0, '0);
      end
    endcase
    pred_buf[pred_n-1].last = 1'b1;
  endfunction

  task automatic note_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Offer one request, hold it until taken, then record what it should cause
  task automatic issue_request(input sched_cmd_t c, input logic typed,
                               input sched_res_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.cmd            <= c.cmd;
    req_ch.task_handle    <= c.handle;
    req_ch.delay_ms       <= c.delay_ms;
    req_ch.period_ms      <= c.period_ms;
    req_ch.slot_to_delete <= c.del_slot;
    do @(posedge clk); while (!req_ch.ready);
    predict_sched(c);
    if (typed) begin
      due_results.push_back(want);
    end else begin
      for (int k = 0; k < pred_n; k++) due_results.push_back(pred_buf[k]);
    end
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on run length
  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: stall ready at the rate of the current phase
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    sched_res_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (due_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result kind %0d slot %0d handle %h last %0b",
                                res_ch.kind, res_ch.slot, res_ch.run_handle, res_ch.last));
      end else begin
        want = due_results.pop_front();
        if (res_ch.kind !== want.kind || res_ch.slot !== want.slot ||
            res_ch.run_handle !== want.handle || res_ch.last !== want.last)
          note_mismatch($sformatf(
            "got kind %0d slot %0d handle %h last %0b, want %0d %0d %h %0b",
            res_ch.kind, res_ch.slot, res_ch.run_handle, res_ch.last,
            want.kind, want.slot, want.handle, want.last));
      end
    end
  end

  // Stimulus
  initial begin
    sched_cmd_t c;
    int         r;

    rst_n                 <= 1'b0;
    req_ch.valid          <= 1'b0;
    req_ch.cmd            <= CMD_TICK;
    req_ch.task_handle    <= '0;
    req_ch.delay_ms       <= '0;
    req_ch.period_ms      <= '0;
    req_ch.slot_to_delete <= '0;
    for (int i = 0; i < SLOTS; i++) clear_slot(i);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table with no idling
    for (int i = 0; i < DIR_N; i++)
      issue_request(dir_tab[i].c, dir_tab[i].typed, dir_tab[i].want);

    // Saturate the pending count of a one-shot task beside a periodic one, then drain
    for (int i = 0; i < SLOTS; i++)
      issue_request('{CMD_DEL, 16'h0, 32'd0, 32'd0, DEL_W'(i)}, 1'b0, NO_RES);
    issue_request('{CMD_ADD, 16'hC001, 32'd3, 32'd0, 3'd0}, 1'b0, NO_RES);
    issue_request('{CMD_ADD, 16'hC002, 32'd0, 32'd10, 3'd0}, 1'b0, NO_RES);
    repeat (SAT_TICKS)
      issue_request('{CMD_TICK, 16'h0, 32'd0, 32'd0, 3'd0}, 1'b0, NO_RES);
    repeat (2)
      issue_request('{CMD_DISP, 16'h0, 32'd0, 32'd0, 3'd0}, 1'b0, NO_RES);

    // Random requests over four idling phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      repeat (RAND_PER_PH) begin
        r = $urandom_range(99);
        if (r < 40)      c.cmd = CMD_TICK;
        else if (r < 65) c.cmd = CMD_ADD;
        else if (r < 80) c.cmd = CMD_DEL;
        else             c.cmd = CMD_DISP;
        c.handle   = HANDLE_W'($urandom);
        c.delay_ms = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(80));
        r = $urandom_range(9);
        if (r < 3)       c.period_ms = 32'($urandom_range(9));
        else if (r == 3) c.period_ms = $urandom;
        else             c.period_ms = 32'($urandom_range(60, 10));
        c.del_slot = DEL_W'($urandom_range(7));
        issue_request(c, 1'b0, NO_RES);
      end
    end

    // Drain outstanding results, then settle
    req_ch.valid   <= 1'b0;
    recv_stall_pct = 0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
